/* design/ilp_pkg.sv */
// ----------------------------------------------------------------------------
// ilp_pkg: shared types and constants for the integer literal parser
// Holds widths, the character class record, the finished-literal record,
// radix and suffix codes, ladder rungs and error codes.
// ----------------------------------------------------------------------------
package ilp_pkg;

    // accumulator width and external value width
    localparam int VALUE_WIDTH = 64;
    localparam int OUT_WIDTH   = 64;
    localparam int SUM_WIDTH   = VALUE_WIDTH + 4;

    // stream widths
    localparam int IN_TDATA_WIDTH  = 8;
    localparam int OUT_TDATA_WIDTH = 72;

    // queue between classifier and executor
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        RX_DEC,
        RX_HEX,
        RX_OCT,
        RX_BIN
    } t_radix;

    typedef enum logic [1:0] {
        SK_NONE,
        SK_U,
        SK_L,
        SK_H
    } t_sfx;

    // suffix flag bit positions
    localparam int SF_U  = 0;
    localparam int SF_L  = 1;
    localparam int SF_LL = 2;
    localparam int SF_H  = 3;
    localparam int SF_HH = 4;

    // ladder rungs, type code is {rung, unsigned}
    localparam logic [2:0] RUNG_CHAR  = 3'd0;
    localparam logic [2:0] RUNG_SHORT = 3'd1;
    localparam logic [2:0] RUNG_INT   = 3'd2;
    localparam logic [2:0] RUNG_LONG  = 3'd3;
    localparam logic [2:0] RUNG_LLONG = 3'd4;

    localparam logic [3:0] TC_NONE = 4'd0;

    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_CHAR  = 2'd1;
    localparam logic [1:0] ERR_RANGE = 2'd2;

    // one classified character
    typedef struct packed {
        logic       last;
        logic       is_zero;
        logic       is_x;
        logic       is_b;
        logic       dig_ok;
        logic [3:0] dig;
        t_sfx       sfx;
        logic       sfx_up;
    } t_cls;

    // one finished literal, ready for type selection
    typedef struct packed {
        logic [VALUE_WIDTH-1:0] accum;
        logic [4:0]             flags;
        logic                   dec;
        logic                   ovf;
        logic                   cerr;
    } t_fin;

endpackage

/* design/integer_literal_parser.sv */
// ----------------------------------------------------------------------------
// integer_literal_parser: streaming C integer literal parser
// Characters of a literal come in one per transfer on the slave stream, the
// final one marked by tlast. Base prefix, digits and U/L/LL/H/HH suffixes are
// decoded and one result per literal leaves on the master stream.
//
// Use:
//   s_axis: tdata carries one ASCII character, tlast marks the last one.
//   m_axis: one transfer per literal with value, type code and error.
//   One character is taken per clock while the queue has room; literals
//   follow each other with no gap. The result is registered in turn in the
//   classifier queue, the executor register and the output register.
//   A four-entry queue sits between the classifier and the executor; when
//   the receiver stalls, the output and finished-literal registers hold and
//   the queue fills before s_axis_tready drops.
//   After reset the parser waits for the first character of a new literal
//   with all state cleared.
// ----------------------------------------------------------------------------
module integer_literal_parser
    import ilp_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [IN_TDATA_WIDTH-1:0]  s_axis_tdata,   // [7:0] ch
    input  logic                       s_axis_tlast,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [OUT_TDATA_WIDTH-1:0] m_axis_tdata    // [63:0] value, [67:64] type_code,
                                                       // [69:68] error, [71:70] zero
);

    t_cls                 cls;
    t_cls                 q_data;
    logic                 q_valid;
    logic                 q_pop;
    logic                 fin_valid;
    logic                 fin_ready;
    t_fin                 fin;
    logic [OUT_WIDTH-1:0] value;
    logic [3:0]           type_code;
    logic [1:0]           error;

    // classify incoming characters
    ilp_front u_front (
        .i_ch   (s_axis_tdata),
        .i_last (s_axis_tlast),
        .o_cls  (cls)
    );

    // decoupling queue
    ilp_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (s_axis_tvalid),
        .o_push_ready (s_axis_tready),
        .i_push_data  (cls),
        .o_pop_valid  (q_valid),
        .i_pop        (q_pop),
        .o_pop_data   (q_data)
    );

    // parse state machine
    ilp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_data    (q_data),
        .o_q_pop     (q_pop),
        .o_fin_valid (fin_valid),
        .i_fin_ready (fin_ready),
        .o_fin       (fin)
    );

    // type selection and output
    ilp_result u_result (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fin_valid (fin_valid),
        .o_fin_ready (fin_ready),
        .i_fin       (fin),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_value     (value),
        .o_type_code (type_code),
        .o_error     (error)
    );

    // pack result fields
    assign m_axis_tdata = {2'b00, error, type_code, value};

endmodule

/* design/ilp_front.sv */
// ----------------------------------------------------------------------------
// ilp_front: character classifier
// Decodes each incoming character into digit, prefix and suffix classes.
// ----------------------------------------------------------------------------
module ilp_front
    import ilp_pkg::*;
(
    input  logic [7:0] i_ch,
    input  logic       i_last,
    output t_cls       o_cls
);

    // digit value and class flags
    always_comb begin
        o_cls        = '0;
        o_cls.last   = i_last;
        o_cls.is_zero = (i_ch == "0");
        o_cls.is_x   = (i_ch == "x") || (i_ch == "X");
        o_cls.is_b   = (i_ch == "b") || (i_ch == "B");
        if (i_ch inside {["0":"9"]}) begin
            o_cls.dig_ok = 1'b1;
            o_cls.dig    = 4'(i_ch - 8'("0"));
        end else if (i_ch inside {["A":"F"]}) begin
            o_cls.dig_ok = 1'b1;
            o_cls.dig    = 4'(i_ch - 8'("A") + 8'd10);
        end else if (i_ch inside {["a":"f"]}) begin
            o_cls.dig_ok = 1'b1;
            o_cls.dig    = 4'(i_ch - 8'("a") + 8'd10);
        end
        // suffix letter kind, case kept for doubled letters
        o_cls.sfx_up = ~i_ch[5];
        if (i_ch == "U" || i_ch == "u") begin
            o_cls.sfx = SK_U;
        end else if (i_ch == "L" || i_ch == "l") begin
            o_cls.sfx = SK_L;
        end else if (i_ch == "H" || i_ch == "h") begin
            o_cls.sfx = SK_H;
        end else begin
            o_cls.sfx = SK_NONE;
        end
    end

endmodule

/* design/ilp_queue.sv */
// ----------------------------------------------------------------------------
// ilp_queue: short queue of classified characters
// Decouples the input stream from the executor so each side stalls alone.
// ----------------------------------------------------------------------------
module ilp_queue
    import ilp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    output logic o_push_ready,
    input  t_cls i_push_data,
    output logic o_pop_valid,
    input  logic i_pop,
    output t_cls o_pop_data
);

    t_cls                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wptr;
    logic [QUEUE_AW-1:0] r_rptr;
    logic [QUEUE_AW:0]   r_count;
    logic                push;
    logic                pop;

    assign o_push_ready = (r_count != (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop && o_pop_valid;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= i_push_data;
        end
    end

endmodule

/* design/ilp_back.sv */
// ----------------------------------------------------------------------------
// ilp_back: literal executor
// Runs the prefix, digit and suffix state machine one character per cycle
// unless the result stage stalls, and hands each finished literal to it.
// ----------------------------------------------------------------------------
module ilp_back
    import ilp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_q_valid,
    input  t_cls i_q_data,
    output logic o_q_pop,
    output logic o_fin_valid,
    input  logic i_fin_ready,
    output t_fin o_fin
);

    typedef enum logic [1:0] {
        PH_START,
        PH_ZERO,
        PH_DIGITS,
        PH_SUFFIX
    } t_phase;

    t_phase                 r_phase, n_phase;
    t_radix                 r_radix, n_radix;
    logic [VALUE_WIDTH-1:0] r_accum, n_accum;
    logic                   r_ovf, n_ovf;
    logic [4:0]             r_flags, n_flags;
    logic                   r_pend, n_pend;
    logic                   r_pend_h, n_pend_h;
    logic                   r_pend_up, n_pend_up;
    logic                   r_cerr, n_cerr;
    logic                   r_fin_valid;
    t_fin                   r_fin;

    t_radix                 eff_radix;
    logic                   dig_lt_base;
    logic [SUM_WIDTH-1:0]   prod;
    logic [SUM_WIDTH-1:0]   sum;
    logic [4:0]             s_flags;
    logic                   s_pend, s_pend_h, s_pend_up, s_err;
    logic [4:0]             fin_flags;
    logic                   fin_free;
    logic                   pop;

    assign fin_free    = !r_fin_valid || i_fin_ready;
    assign pop         = i_q_valid && (!i_q_data.last || fin_free);
    assign o_q_pop     = pop;
    assign o_fin_valid = r_fin_valid;
    assign o_fin       = r_fin;

    // digit range and multiply-add by the base
    assign eff_radix = (r_phase == PH_START) ? RX_DEC : r_radix;
    always_comb begin
        case (eff_radix)
            RX_DEC: begin
                dig_lt_base = (i_q_data.dig < 4'd10);
                prod = SUM_WIDTH'({r_accum, 3'b000}) + SUM_WIDTH'({r_accum, 1'b0});
            end
            RX_HEX: begin
                dig_lt_base = 1'b1;
                prod = SUM_WIDTH'({r_accum, 4'b0000});
            end
            RX_OCT: begin
                dig_lt_base = (i_q_data.dig < 4'd8);
                prod = SUM_WIDTH'({r_accum, 3'b000});
            end
            default: begin
                dig_lt_base = (i_q_data.dig < 4'd2);
                prod = SUM_WIDTH'({r_accum, 1'b0});
            end
        endcase
    end
    assign sum = prod + SUM_WIDTH'(i_q_data.dig);

    // suffix letter handling with doubled-letter tracking
    always_comb begin
        s_flags   = r_flags;
        s_pend    = r_pend;
        s_pend_h  = r_pend_h;
        s_pend_up = r_pend_up;
        s_err     = 1'b0;
        if (r_pend && i_q_data.sfx == (r_pend_h ? SK_H : SK_L)
                && i_q_data.sfx_up == r_pend_up) begin
            if (r_pend_h) begin
                s_flags[SF_HH] = 1'b1;
            end else begin
                s_flags[SF_LL] = 1'b1;
            end
            s_pend = 1'b0;
        end else begin
            if (r_pend) begin
                if (r_pend_h) begin
                    s_flags[SF_H] = 1'b1;
                end else begin
                    s_flags[SF_L] = 1'b1;
                end
                s_pend = 1'b0;
            end
            case (i_q_data.sfx)
                SK_U: begin
                    s_flags[SF_U] = 1'b1;
                end
                SK_L: begin
                    s_pend    = 1'b1;
                    s_pend_h  = 1'b0;
                    s_pend_up = i_q_data.sfx_up;
                end
                SK_H: begin
                    s_pend    = 1'b1;
                    s_pend_h  = 1'b1;
                    s_pend_up = i_q_data.sfx_up;
                end
                default: begin
                    s_err = 1'b1;
                end
            endcase
        end
    end

    // next state for one character
    always_comb begin
        n_phase   = r_phase;
        n_radix   = r_radix;
        n_accum   = r_accum;
        n_ovf     = r_ovf;
        n_flags   = r_flags;
        n_pend    = r_pend;
        n_pend_h  = r_pend_h;
        n_pend_up = r_pend_up;
        n_cerr    = r_cerr;
        if (!r_cerr) begin
            if (r_phase == PH_START && i_q_data.is_zero) begin
                n_radix = RX_OCT;
                n_phase = PH_ZERO;
            end else if (r_phase == PH_ZERO && i_q_data.is_x) begin
                n_radix = RX_HEX;
                n_phase = PH_DIGITS;
            end else if (r_phase == PH_ZERO && i_q_data.is_b) begin
                n_radix = RX_BIN;
                n_phase = PH_DIGITS;
            end else if (r_phase == PH_SUFFIX) begin
                n_flags   = s_flags;
                n_pend    = s_pend;
                n_pend_h  = s_pend_h;
                n_pend_up = s_pend_up;
                n_cerr    = s_err;
            end else begin
                // digit position: start, after leading zero, or digits
                n_radix = eff_radix;
                n_phase = PH_DIGITS;
                if (i_q_data.dig_ok && dig_lt_base) begin
                    n_accum = sum[VALUE_WIDTH-1:0];
                    if (sum[SUM_WIDTH-1:VALUE_WIDTH] != '0) begin
                        n_ovf = 1'b1;
                    end
                end else if (i_q_data.sfx != SK_NONE) begin
                    n_phase   = PH_SUFFIX;
                    n_flags   = s_flags;
                    n_pend    = s_pend;
                    n_pend_h  = s_pend_h;
                    n_pend_up = s_pend_up;
                    n_cerr    = s_err;
                end else begin
                    n_cerr = 1'b1;
                end
            end
        end
        // fold a single pending letter into the flags at the end
        fin_flags = n_flags;
        if (n_pend) begin
            if (n_pend_h) begin
                fin_flags[SF_H] = 1'b1;
            end else begin
                fin_flags[SF_L] = 1'b1;
            end
        end
    end

    // state and finished-literal register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_START;
            r_radix     <= RX_DEC;
            r_accum     <= '0;
            r_ovf       <= 1'b0;
            r_flags     <= '0;
            r_pend      <= 1'b0;
            r_pend_h    <= 1'b0;
            r_pend_up   <= 1'b0;
            r_cerr      <= 1'b0;
            r_fin_valid <= 1'b0;
        end else begin
            if (i_fin_ready) begin
                r_fin_valid <= 1'b0;
            end
            if (pop) begin
                if (i_q_data.last) begin
                    r_fin_valid <= 1'b1;
                    r_fin.accum <= n_accum;
                    r_fin.flags <= fin_flags;
                    r_fin.dec   <= (n_radix == RX_DEC);
                    r_fin.ovf   <= n_ovf;
                    r_fin.cerr  <= n_cerr;
                    r_phase     <= PH_START;
                    r_radix     <= RX_DEC;
                    r_accum     <= '0;
                    r_ovf       <= 1'b0;
                    r_flags     <= '0;
                    r_pend      <= 1'b0;
                    r_pend_h    <= 1'b0;
                    r_pend_up   <= 1'b0;
                    r_cerr      <= 1'b0;
                end else begin
                    r_phase   <= n_phase;
                    r_radix   <= n_radix;
                    r_accum   <= n_accum;
                    r_ovf     <= n_ovf;
                    r_flags   <= n_flags;
                    r_pend    <= n_pend;
                    r_pend_h  <= n_pend_h;
                    r_pend_up <= n_pend_up;
                    r_cerr    <= n_cerr;
                end
            end
        end
    end

endmodule

/* design/ilp_result.sv */
// ----------------------------------------------------------------------------
// ilp_result: type selection and output register
// Walks the signed/unsigned ladder for a finished literal and holds the
// result until the receiver takes it.
// ----------------------------------------------------------------------------
module ilp_result
    import ilp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_fin_valid,
    output logic                 o_fin_ready,
    input  t_fin                 i_fin,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [OUT_WIDTH-1:0] o_value,
    output logic [3:0]           o_type_code,
    output logic [1:0]           o_error
);

    logic                 r_valid;
    logic [OUT_WIDTH-1:0] r_value;
    logic [3:0]           r_code;
    logic [1:0]           r_err;

    logic [63:0]          ext;
    logic                 u, uu;
    logic                 f32s, f32u, f64s;
    logic [2:0]           start;
    logic [2:0]           rung64;
    logic [OUT_WIDTH-1:0] n_value;
    logic [3:0]           n_code;
    logic [1:0]           n_err;

    assign o_fin_ready = !r_valid || i_ready;
    assign o_valid     = r_valid;
    assign o_value     = r_value;
    assign o_type_code = r_code;
    assign o_error     = r_err;

    // limit checks
    assign ext  = 64'(i_fin.accum);
    assign u    = i_fin.flags[SF_U];
    assign uu   = !i_fin.dec;
    assign f32s = (ext[63:31] == '0);
    assign f32u = (ext[63:32] == '0);
    assign f64s = !ext[63];

    // starting rung from the suffix flags
    always_comb begin
        if (i_fin.flags[SF_HH]) begin
            start = RUNG_CHAR;
        end else if (i_fin.flags[SF_H]) begin
            start = RUNG_SHORT;
        end else if (i_fin.flags[SF_L]) begin
            start = RUNG_LONG;
        end else if (i_fin.flags[SF_LL]) begin
            start = RUNG_LLONG;
        end else begin
            start = RUNG_INT;
        end
        rung64 = (start < RUNG_LONG) ? RUNG_LONG : start;
    end

    // ladder walk: 32-bit rungs share limits, so one try there, then 64-bit
    always_comb begin
        n_value = '0;
        n_code  = TC_NONE;
        n_err   = ERR_NONE;
        if (i_fin.cerr) begin
            n_err = ERR_CHAR;
        end else if (i_fin.ovf) begin
            n_err = ERR_RANGE;
        end else if (start < RUNG_LONG && !u && f32s) begin
            n_code  = {start, 1'b0};
            n_value = OUT_WIDTH'(ext);
        end else if (start < RUNG_LONG && (u || uu) && f32u) begin
            n_code  = {start, 1'b1};
            n_value = OUT_WIDTH'(ext);
        end else if (!u && f64s) begin
            n_code  = {rung64, 1'b0};
            n_value = OUT_WIDTH'(ext);
        end else if (u || uu) begin
            n_code  = {rung64, 1'b1};
            n_value = OUT_WIDTH'(ext);
        end else begin
            n_err = ERR_RANGE;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_fin_ready) begin
            r_valid <= i_fin_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_fin_ready && i_fin_valid) begin
            r_value <= n_value;
            r_code  <= n_code;
            r_err   <= n_err;
        end
    end

endmodule

/* sim/integer_literal_parser_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// integer_literal_parser_tb: self-checking bench for the integer literal parser
// Streams C integer literals one character per transfer, a directed set of
// prefix, suffix and error cases first and then random literals, some
// well formed, some at the type limits, some corrupted and some pure noise.
// A scoreboard predicts value, type code and error for every literal and
// checks each result transfer against the oldest prediction. Both stream
// sides idle and stall at random.
// ----------------------------------------------------------------------------
module integer_literal_parser_tb;
    import ilp_pkg::*;

    typedef logic [7:0] t_chars[$];

    typedef enum logic [1:0] {
        SCAN_START,
        SCAN_ZERO,
        SCAN_DIGITS,
        SCAN_SUFFIX
    } t_scan;

    typedef struct {
        logic [63:0] value;
        logic [3:0]  type_code;
        logic [1:0]  error;
    } t_literal_result;

    localparam logic [7:0]  NO_LETTER   = 8'h00;
    localparam logic [63:0] SMAX_NARROW = 64'h0000_0000_7FFF_FFFF;
    localparam logic [63:0] UMAX_NARROW = 64'h0000_0000_FFFF_FFFF;
    localparam logic [63:0] SMAX_WIDE   = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] UMAX_WIDE   = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam int          RANDOM_CHARS = 1900;

    // scoreboard: predicts each literal and checks the result stream
    class literal_scoreboard;
        t_literal_result results_due[$];
        int     errors;
        int     literals_checked;
        int     char_errors;
        int     range_errors;
        t_scan  scan;
        t_radix radix;
        logic [63:0] accum;
        logic        overflowed;
        logic [4:0]  flags;
        logic [7:0]  pending_letter;
        logic        bad_char;

        function new();
            errors = 0;
            literals_checked = 0;
            char_errors = 0;
            range_errors = 0;
            clear_literal();
        endfunction

        function void clear_literal();
            scan = SCAN_START;
            radix = RX_DEC;
            accum = '0;
            overflowed = 1'b0;
            flags = '0;
            pending_letter = NO_LETTER;
            bad_char = 1'b0;
        endfunction

        function int digit_value(logic [7:0] c);
            if (c >= "0" && c <= "9") return int'(c - "0");
            if (c >= "A" && c <= "F") return int'(c - "A") + 10;
            if (c >= "a" && c <= "f") return int'(c - "a") + 10;
            return -1;
        endfunction

        function bit is_suffix_letter(logic [7:0] c);
            return c == "U" || c == "u" || c == "L" || c == "l" || c == "H" || c == "h";
        endfunction

        // a single L or H becomes a flag once it can no longer be doubled
        function void flush_letter();
            if (pending_letter == "L" || pending_letter == "l") flags[SF_L] = 1'b1;
            else if (pending_letter == "H" || pending_letter == "h") flags[SF_H] = 1'b1;
            pending_letter = NO_LETTER;
        endfunction

        function void suffix_letter(logic [7:0] c);
            if (pending_letter != NO_LETTER) begin
                if (c == pending_letter) begin
                    if (c == "L" || c == "l") flags[SF_LL] = 1'b1;
                    else flags[SF_HH] = 1'b1;
                    pending_letter = NO_LETTER;
                    return;
                end
                flush_letter();
            end
            if (c == "U" || c == "u") flags[SF_U] = 1'b1;
            else if (c == "L" || c == "l" || c == "H" || c == "h") pending_letter = c;
            else bad_char = 1'b1;
        endfunction

        function void digit_or_suffix(logic [7:0] c);
            int          d;
            int          base;
            logic [67:0] wide;
            case (radix)
                RX_HEX:  base = 16;
                RX_OCT:  base = 8;
                RX_BIN:  base = 2;
                default: base = 10;
            endcase
            d = digit_value(c);
            if (d >= 0 && d < base) begin
                wide = 68'(accum) * 68'(base) + 68'(d);
                if (wide[67:64] != 4'd0) overflowed = 1'b1;
                accum = wide[63:0];
            end else if (is_suffix_letter(c)) begin
                scan = SCAN_SUFFIX;
                suffix_letter(c);
            end else begin
                bad_char = 1'b1;
            end
        endfunction

        // type ladder walk from the rung the suffix selects
        function void close_literal();
            t_literal_result res;
            logic [2:0] rung;
            logic       want_u;
            logic       allow_u;
            logic       found;
            logic [63:0] smax;
            logic [63:0] umax;
            flush_letter();
            res.value = '0;
            res.type_code = TC_NONE;
            res.error = ERR_NONE;
            if (bad_char) begin
                res.error = ERR_CHAR;
            end else if (overflowed) begin
                res.error = ERR_RANGE;
            end else begin
                want_u = flags[SF_U];
                allow_u = radix != RX_DEC;
                found = 1'b0;
                if (flags[SF_HH]) rung = RUNG_CHAR;
                else if (flags[SF_H]) rung = RUNG_SHORT;
                else if (flags[SF_L]) rung = RUNG_LONG;
                else if (flags[SF_LL]) rung = RUNG_LLONG;
                else rung = RUNG_INT;
                while (!found && rung <= RUNG_LLONG) begin
                    smax = (rung < RUNG_LONG) ? SMAX_NARROW : SMAX_WIDE;
                    umax = (rung < RUNG_LONG) ? UMAX_NARROW : UMAX_WIDE;
                    if (!want_u && accum <= smax) begin
                        res.type_code = {rung, 1'b0};
                        found = 1'b1;
                    end else if ((want_u || allow_u) && accum <= umax) begin
                        res.type_code = {rung, 1'b1};
                        found = 1'b1;
                    end else begin
                        rung = rung + 3'd1;
                    end
                end
                if (found) res.value = accum;
                else res.error = ERR_RANGE;
            end
            if (res.error == ERR_CHAR) char_errors++;
            if (res.error == ERR_RANGE) range_errors++;
            results_due.push_back(res);
            clear_literal();
        endfunction

        // one character accepted on the input stream
        function void note_char(logic [7:0] c, logic last);
            if (!bad_char) begin
                case (scan)
                    SCAN_START: begin
                        if (c == "0") begin
                            radix = RX_OCT;
                            scan = SCAN_ZERO;
                        end else begin
                            radix = RX_DEC;
                            scan = SCAN_DIGITS;
                            digit_or_suffix(c);
                        end
                    end
                    SCAN_ZERO: begin
                        scan = SCAN_DIGITS;
                        if (c == "x" || c == "X") radix = RX_HEX;
                        else if (c == "b" || c == "B") radix = RX_BIN;
                        else digit_or_suffix(c);
                    end
                    SCAN_DIGITS: digit_or_suffix(c);
                    default: suffix_letter(c);
                endcase
            end
            if (last) close_literal();
        endfunction

        // one result accepted on the output stream
        function void check_result(logic [OUT_TDATA_WIDTH-1:0] data);
            t_literal_result want;
            if (results_due.size() == 0) begin
                $error("result transfer with no literal outstanding: %h", data);
                errors++;
                return;
            end
            want = results_due.pop_front();
            literals_checked++;
            if (data[63:0] !== want.value) begin
                $error("value: expected %h, got %h", want.value, data[63:0]);
                errors++;
            end
            if (data[67:64] !== want.type_code) begin
                $error("type_code: expected %0d, got %0d", want.type_code, data[67:64]);
                errors++;
            end
            if (data[69:68] !== want.error) begin
                $error("error: expected %0d, got %0d", want.error, data[69:68]);
                errors++;
            end
        endfunction

        function int outstanding();
            return results_due.size();
        endfunction
    endclass

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       s_axis_tvalid = 1'b0;
    logic                       s_axis_tready;
    logic [IN_TDATA_WIDTH-1:0]  s_axis_tdata = '0;  // [7:0] ch
    logic                       s_axis_tlast = 1'b0;
    logic                       m_axis_tvalid;
    logic                       m_axis_tready = 1'b0;
    logic [OUT_TDATA_WIDTH-1:0] m_axis_tdata;       // [63:0] value, [67:64] type_code,
                                                    // [69:68] error, [71:70] zero

    literal_scoreboard sb = new();
    int chars_sent = 0;
    int send_run_left = 0;
    bit send_steady = 1'b0;

    integer_literal_parser dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // clock
    always #5 i_clk = ~i_clk;

    // watchdog
    initial begin
        #20_000_000;
        $display("integer_literal_parser verification failed");
        $finish;
    end

    // idle length: mostly none or short, now and then long
    function automatic int idle_len(bit steady);
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // receiver stalls
    initial begin
        int stall;
        int run_left;
        bit steady;
        run_left = 0;
        steady = 1'b0;
        forever begin
            @(negedge i_clk);
            if (run_left == 0) begin
                steady = ($urandom_range(0, 3) == 0);
                run_left = $urandom_range(20, 120);
            end
            run_left--;
            stall = idle_len(steady);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    // output monitor
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    end

    // one character transfer, with a random gap ahead of it
    task automatic send_char(input logic [7:0] c, input logic last);
        int gap;
        if (send_run_left == 0) begin
            send_steady = ($urandom_range(0, 3) == 0);
            send_run_left = $urandom_range(10, 60);
        end
        send_run_left--;
        gap = idle_len(send_steady);
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= c;
        s_axis_tlast <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_char(c, last);
        chars_sent++;
    endtask

    task automatic send_literal(input t_chars lit);
        foreach (lit[i]) send_char(lit[i], i == lit.size() - 1);
    endtask

    function automatic t_chars text_bytes(string s);
        t_chars q;
        for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
        return q;
    endfunction

    // values at and around the type limits
    function automatic logic [63:0] boundary_value();
        logic [63:0] v;
        case ($urandom_range(0, 7))
            0:       v = 64'd0;
            1:       v = SMAX_NARROW;
            2:       v = SMAX_NARROW + 64'd1;
            3:       v = UMAX_NARROW;
            4:       v = UMAX_NARROW + 64'd1;
            5:       v = SMAX_WIDE;
            6:       v = SMAX_WIDE + 64'd1;
            default: v = UMAX_WIDE;
        endcase
        if ($urandom_range(0, 2) == 0) v = v - 64'd1;
        return v;
    endfunction

    function automatic logic [63:0] random_magnitude(t_radix rx);
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 64'($urandom_range(0, 999));
        if (rx == RX_BIN && r < 95) return 64'($urandom_range(0, 65535));
        if (r < 80) return 64'($urandom);
        return {$urandom, $urandom};
    endfunction

    // literal text of a value in a given base, random letter case
    function automatic t_chars format_literal(logic [63:0] v, t_radix rx);
        string  body;
        string  pfx;
        t_chars q;
        case (rx)
            RX_HEX: begin
                pfx = $urandom_range(0, 1) ? "0x" : "0X";
                body = {pfx, $sformatf("%0h", v)};
            end
            RX_OCT: body = {"0", $sformatf("%0o", v)};
            RX_BIN: begin
                pfx = $urandom_range(0, 1) ? "0b" : "0B";
                body = {pfx, $sformatf("%0b", v)};
            end
            default: body = $sformatf("%0d", v);
        endcase
        q = text_bytes(body);
        if (rx != RX_DEC && $urandom_range(0, 5) == 0) q.insert(2, "0");
        foreach (q[i]) begin
            if (i >= 2 && q[i] >= "a" && q[i] <= "f" && $urandom_range(0, 1) == 1)
                q[i] = q[i] - 8'd32;
        end
        return q;
    endfunction

    function automatic string pick_suffix();
        case ($urandom_range(0, 27))
            0:  return "u";
            1:  return "U";
            2:  return "l";
            3:  return "L";
            4:  return "ll";
            5:  return "LL";
            6:  return "ul";
            7:  return "Lu";
            8:  return "ULL";
            9:  return "llu";
            10: return "h";
            11: return "H";
            12: return "hh";
            13: return "HH";
            14: return "uh";
            15: return "hhU";
            16: return "hH";
            17: return "lL";
            18: return "LLL";
            19: return "Hl";
            default: return "";
        endcase
    endfunction

    // random literal: mostly well formed, some at limits, corrupted or noise
    function automatic t_chars random_literal();
        t_chars q;
        t_radix rx;
        int     kind;
        int     pos;
        int     n;
        kind = $urandom_range(0, 99);
        rx = t_radix'($urandom_range(0, 3));
        if (kind < 10) begin
            n = $urandom_range(1, 5);
            repeat (n) q.push_back(8'($urandom_range(0, 255)));
            return q;
        end
        if (kind < 35) begin
            q = format_literal(boundary_value(), rx);
            // one digit more can push a wide value past the accumulator
            if ($urandom_range(0, 3) == 0) q.push_back("1");
        end else begin
            q = format_literal(random_magnitude(rx), rx);
        end
        q = {q, text_bytes(pick_suffix())};
        if (kind >= 86) begin
            pos = $urandom_range(0, q.size() - 1);
            case ($urandom_range(0, 2))
                0:       q[pos] = 8'($urandom_range(0, 255));
                1:       q.insert(pos, 8'($urandom_range(0, 255)));
                default: q.push_back(8'("0" + $urandom_range(0, 9)));
            endcase
        end
        return q;
    endfunction

    // main stimulus
    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: prefixes, suffix forms, ladder limits and error cases
        send_literal(text_bytes("0"));
        send_literal(text_bytes("0x"));
        send_literal(text_bytes("0B"));
        send_literal(text_bytes("U"));
        send_literal(text_bytes("09"));
        send_literal(text_bytes("0b2"));
        send_char(8'h00, 1'b1);
        send_char(8'hFF, 1'b1);
        send_literal(text_bytes("1u2"));
        send_literal(text_bytes("1zq"));
        send_literal(text_bytes("0x10000000000000000"));
        send_literal(text_bytes("0x10000000000000000g"));
        send_literal(text_bytes("18446744073709551615"));
        send_literal(text_bytes("0XFFFFffffFFFFffffuLL"));
        send_literal(text_bytes("2147483648"));
        send_literal(text_bytes("4294967295u"));
        send_literal(text_bytes("0x80000000"));
        send_literal(text_bytes("7hh"));
        send_literal(text_bytes("3hH"));
        send_literal(text_bytes("1LLL"));
        send_literal(text_bytes("1lL"));
        send_literal(text_bytes("0777U"));

        // random literals up to the character budget
        while (chars_sent < RANDOM_CHARS) send_literal(random_literal());

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("streamed %0d characters forming %0d literals",
                 chars_sent, sb.literals_checked);
        $display("literals rejected: %0d for a bad character, %0d as out of range",
                 sb.char_errors, sb.range_errors);
        if (sb.errors == 0) begin
            $display("integer_literal_parser verification clean");
        end else begin
            $display("integer_literal_parser verification failed");
        end
        $finish;
    end

endmodule
